// ===== rtl/lfa_pkg.sv =====
// Package for the Lorentz field acceleration block: action and status codes, widths,
// Q10.10 field unpack helper and 32-bit saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfa_pkg;
	localparam int unsigned DEFAULT_BOX_SLOTS = 8;
	localparam int unsigned CFG_W = 63;

	typedef enum logic [1:0] {
		ACT_COMPUTE = 2'd0,
		ACT_LOAD_E  = 2'd1,
		ACT_LOAD_B  = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UPDATED = 2'd1,
		ST_ZMASS   = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	localparam logic [1:0] REG_GRAVITY  = 2'd0;
	localparam logic [1:0] REG_ELECTRIC = 2'd1;
	localparam logic [1:0] REG_MAGNETIC = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	function automatic logic signed [20:0] q10_part(input logic [CFG_W-1:0] r,
			input logic [1:0] idx);
		logic signed [20:0] f;
		unique case (idx)
			2'd0: f = r[20:0];
			2'd1: f = r[41:21];
			default: f = r[62:42];
		endcase
		return f;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic is_sat(input logic signed [65:0] v);
		return (v > 66'sh0_7FFF_FFFF) || (v < -66'sh0_8000_0000);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/lfa_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface lfa_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [2:0] slot;
	logic [1:0] axis;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, charge;
	logic [31:0] mass;
	modport source (output valid, action, slot, axis, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, charge, mass, input ready);
	modport sink (input valid, action, slot, axis, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, charge, mass, output ready);
endinterface

interface lfa_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] acc_x, acc_y, acc_z;
	logic [1:0] status;
	modport source (output valid, acc_x, acc_y, acc_z, status, input ready);
	modport sink (input valid, acc_x, acc_y, acc_z, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/lfa_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit signed dividend by
// 32-bit unsigned divisor, quotient truncated toward zero. Uses lfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfa_div
	import lfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic done,
	output logic signed [65:0] quotient
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [63:0] num_q;
	logic [32:0] rem_q;
	logic neg_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;

	assign rem_sh = {rem_q[31:0], num_q[63]};
	assign trial = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			num_q <= dividend[63] ? 64'(-dividend) : dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				num_q <= {num_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[62:0], 1'b0};
			end
		end
	end

	// num_q holds the magnitude quotient after 64 shifts
	assign quotient = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
endmodule
`default_nettype wire

// ===== rtl/lfa_cfg.sv =====
// APB register file for gravity, electric and magnetic vectors (64-bit data).
// Uses lfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfa_cfg
	import lfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output logic [CFG_W-1:0] grav,
	output logic [CFG_W-1:0] efld,
	output logic [CFG_W-1:0] bfld
);
	logic [1:0] idx;
	assign idx = paddr[4:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav <= '0;
			efld <= '0;
			bfld <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (idx)
				REG_GRAVITY:  grav <= pwdata[CFG_W-1:0];
				REG_ELECTRIC: efld <= pwdata[CFG_W-1:0];
				REG_MAGNETIC: bfld <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GRAVITY:  prdata = {1'b0, grav};
			REG_ELECTRIC: prdata = {1'b0, efld};
			REG_MAGNETIC: prdata = {1'b0, bfld};
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/lorentz_field_acceleration_top.sv =====
// Top level: box table, sequencer with one shared 32x32 multiplier, adder and
// serial divider. Uses lfa_pkg, lfa_if, lfa_cfg, lfa_div.
`timescale 1ns / 1ps
`default_nettype none
//  channel  dir  beat contents
//  in       in   action slot axis pos_* vel_* charge mass
//  out      out  acc_x acc_y acc_z status
//  apb      in   gravity/electric/magnetic vectors at 0x00/0x08/0x10
// Load/clear and zero-mass beats go from acceptance straight to the result state.
// Compute time is set by the one-bit-per-cycle divider, run once per axis, and
// by the single multiplier walked over products and slots.
// in.ready is low from acceptance until the result beat is taken; the result
// is held in an output register while out.ready is low. Async reset clears
// the box valid bits, the sequencer and the config registers.
module lorentz_field_acceleration_top
	import lfa_pkg::*;
#(
	parameter int unsigned BOX_SLOTS = DEFAULT_BOX_SLOTS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lfa_in_if.sink in,
	lfa_out_if.source out,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam int unsigned SW = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_UNI   = 9'b000000010,
		S_BOX   = 9'b000000100,
		S_BMUL  = 9'b000001000,
		S_FSAT  = 9'b000010000,
		S_FMUL  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_ACC   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	logic [CFG_W-1:0] grav, efld, bfld;
	lfa_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .grav, .efld, .bfld);

	// box table
	logic [BOX_SLOTS-1:0] bvalid_q;
	logic bmag_q [BOX_SLOTS];
	logic [1:0] bdir_q [BOX_SLOTS];
	logic signed [31:0] blo_q [BOX_SLOTS][3];
	logic signed [31:0] bhi_q [BOX_SLOTS][3];
	logic signed [31:0] bstr_q [BOX_SLOTS];

	state_t state_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] chg_q;
	logic [31:0] mass_q;
	logic signed [65:0] force_q [3];
	logic signed [31:0] fs_q [3];
	logic [1:0] ax_q;
	logic [2:0] step_q;
	logic [SW-1:0] slot_q;
	logic bphase_q;
	logic sat_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] acc_q [3];
	logic [1:0] st_q;

	// shared multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] mprod;
	assign mprod = ma * mb;

	logic div_start, div_done;
	logic signed [65:0] quot;
	lfa_div u_div (.clk, .arst_n, .start(div_start), .dividend(prod_q),
		.divisor(mass_q), .done(div_done), .quotient(quot));

	logic [1:0] ax_p1, ax_p2;
	assign ax_p1 = (ax_q == AXIS_Z) ? AXIS_X : ax_q + 2'd1;
	assign ax_p2 = (ax_p1 == AXIS_Z) ? AXIS_X : ax_p1 + 2'd1;

	logic in_box;
	always_comb begin
		in_box = bvalid_q[slot_q];
		for (int i = 0; i < 3; i++)
			in_box = in_box && (blo_q[slot_q][i] < p_q[i]) && (bhi_q[slot_q][i] > p_q[i]);
	end

	logic [1:0] bd;
	assign bd = bdir_q[slot_q];

	// axes after the box direction, wrapping z to x
	logic [1:0] bd_p1, bd_p2;
	assign bd_p1 = (bd == AXIS_Z) ? AXIS_X : bd + 2'd1;
	assign bd_p2 = (bd_p1 == AXIS_Z) ? AXIS_X : bd_p1 + 2'd1;

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		priority case (1'b1)
			state_q[1]: begin
				// step 0: v[ax+1]*b[ax+2], step 1: v[ax+2]*b[ax+1]
				ma = step_q[0] ? v_q[ax_p2] : v_q[ax_p1];
				mb = 32'(step_q[0] ? q10_part(bfld, ax_p1) : q10_part(bfld, ax_p2));
			end
			state_q[3]: begin
				ma = bstr_q[slot_q];
				mb = bphase_q ? v_q[bd_p1] : v_q[bd_p2];
			end
			state_q[5]: begin
				ma = fs_q[ax_q];
				mb = chg_q;
			end
			default: ;
		endcase
	end

	logic in_fire, out_fire;
	assign in.ready = state_q == S_IDLE;
	assign in_fire = in.valid && in.ready;
	assign out.valid = state_q == S_OUT;
	assign out_fire = out.valid && out.ready;
	assign out.acc_x = acc_q[0];
	assign out.acc_y = acc_q[1];
	assign out.acc_z = acc_q[2];
	assign out.status = st_q;
	assign div_start = state_q == S_FMUL && step_q[0];

	logic signed [65:0] prod66, gsum;
	assign prod66 = 66'(prod_q);
	assign gsum = 66'(sat32(quot)) + 66'(signed'({q10_part(grav, ax_q), 6'd0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bvalid_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					if (in.action != ACT_COMPUTE) begin
						if (32'(in.slot) < BOX_SLOTS)
							bvalid_q[in.slot[SW-1:0]] <= in.action != ACT_CLEAR;
						state_q <= S_OUT;
					end else if (in.mass == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_UNI;
					end
				end
				S_UNI: if (ax_q == AXIS_Z && step_q == 3'd2) state_q <= S_BOX;
				S_BOX: begin
					if (in_box && bmag_q[slot_q] && bd != 2'd3) state_q <= S_BMUL;
					else if (32'(slot_q) == BOX_SLOTS - 1) state_q <= S_FSAT;
				end
				S_BMUL: if (bphase_q) state_q <= (32'(slot_q) == BOX_SLOTS - 1) ? S_FSAT
					: S_BOX;
				S_FSAT: state_q <= S_FMUL;
				S_FMUL: if (step_q[0]) state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_ACC;
				S_ACC: state_q <= (ax_q == AXIS_Z) ? S_OUT : S_FMUL;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_fire) begin
				p_q[0] <= in.pos_x; p_q[1] <= in.pos_y; p_q[2] <= in.pos_z;
				v_q[0] <= in.vel_x; v_q[1] <= in.vel_y; v_q[2] <= in.vel_z;
				chg_q <= in.charge;
				mass_q <= in.mass;
				ax_q <= AXIS_X;
				step_q <= '0;
				slot_q <= '0;
				bphase_q <= 1'b0;
				sat_q <= 1'b0;
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
				if (in.action != ACT_COMPUTE) begin
					st_q <= ST_UPDATED;
					if (32'(in.slot) < BOX_SLOTS && in.action != ACT_CLEAR) begin
						bmag_q[in.slot[SW-1:0]] <= in.action == ACT_LOAD_B;
						bdir_q[in.slot[SW-1:0]] <= in.axis;
						blo_q[in.slot[SW-1:0]][0] <= in.pos_x;
						blo_q[in.slot[SW-1:0]][1] <= in.pos_y;
						blo_q[in.slot[SW-1:0]][2] <= in.pos_z;
						bhi_q[in.slot[SW-1:0]][0] <= in.vel_x;
						bhi_q[in.slot[SW-1:0]][1] <= in.vel_y;
						bhi_q[in.slot[SW-1:0]][2] <= in.vel_z;
						bstr_q[in.slot[SW-1:0]] <= in.charge;
					end
				end else if (in.mass == '0) begin
					st_q <= ST_ZMASS;
					for (int i = 0; i < 3; i++)
						acc_q[i] <= 32'(signed'({q10_part(grav, 2'(i)), 6'd0}));
				end else begin
					st_q <= ST_OK;
				end
			end
			S_UNI: begin
				// step 0 mult and add, step 1 mult, step 2 subtract and shift
				prod_q <= mprod;
				if (step_q == 3'd0) begin
					force_q[ax_q] <= 66'(signed'({q10_part(efld, ax_q), 16'd0}))
						+ 66'(mprod);
					step_q <= 3'd1;
				end else if (step_q == 3'd1) begin
					step_q <= 3'd2;
				end else begin
					force_q[ax_q] <= (force_q[ax_q] - prod66) >>> 10;
					step_q <= '0;
					ax_q <= (ax_q == AXIS_Z) ? AXIS_X : ax_q + 2'd1;
				end
			end
			S_BOX: begin
				if (in_box && !bmag_q[slot_q] && bd != 2'd3)
					force_q[bd] <= force_q[bd] + 66'(bstr_q[slot_q]);
				if (!(in_box && bmag_q[slot_q] && bd != 2'd3))
					slot_q <= (32'(slot_q) == BOX_SLOTS - 1) ? slot_q : slot_q + SW'(1);
				bphase_q <= 1'b0;
			end
			S_BMUL: begin
				// phase 0: s*v[d+2] into force[d+1]; phase 1: s*v[d+1] out of force[d+2]
				if (!bphase_q) begin
					force_q[(bd == AXIS_Z) ? AXIS_X : bd + 2'd1] <=
						force_q[(bd == AXIS_Z) ? AXIS_X : bd + 2'd1]
						+ (66'(mprod) >>> 16);
					bphase_q <= 1'b1;
				end else begin
					force_q[(bd == AXIS_X) ? AXIS_Z : bd - 2'd1] <=
						force_q[(bd == AXIS_X) ? AXIS_Z : bd - 2'd1]
						- (66'(mprod) >>> 16);
					bphase_q <= 1'b0;
					slot_q <= (32'(slot_q) == BOX_SLOTS - 1) ? slot_q : slot_q + SW'(1);
				end
			end
			S_FSAT: begin
				for (int i = 0; i < 3; i++) fs_q[i] <= sat32(force_q[i]);
				if (is_sat(force_q[0]) || is_sat(force_q[1]) || is_sat(force_q[2]))
					sat_q <= 1'b1;
				ax_q <= AXIS_X;
				step_q <= '0;
			end
			S_FMUL: begin
				if (!step_q[0]) prod_q <= mprod;
				step_q <= step_q[0] ? 3'd0 : 3'd1;
			end
			S_DIV: ;
			S_ACC: begin
				acc_q[ax_q] <= sat32(gsum);
				if (is_sat(quot) || is_sat(gsum) || sat_q) begin
					sat_q <= 1'b1;
					st_q <= ST_SAT;
				end
				ax_q <= (ax_q == AXIS_Z) ? AXIS_X : ax_q + 2'd1;
			end
			S_OUT: ;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !out.valid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.status))
		else $error("result dropped");
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider done out of sequence");
endmodule
`default_nettype wire
